// ===== sv/ps2_device_link_engine_defines.svh =====
// ---------------------------------------------------------------------------
// ps2_device_link_engine_defines
// assertion macros for the ps2 device link engine
// ---------------------------------------------------------------------------
`ifndef PS2_DEVICE_LINK_ENGINE_DEFINES_SVH
`define PS2_DEVICE_LINK_ENGINE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PS2DLE_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2dle check failed");

// next-cycle implication, checked out of reset
`define PS2DLE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2dle check failed");

`endif

// ===== sv/ps2dle_pkg.sv =====
// ---------------------------------------------------------------------------
// ps2dle_pkg
// types and constants of the ps2 device link engine
// ---------------------------------------------------------------------------
package ps2dle_pkg;

    // item commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_QUEUE = 2'd1;
    localparam logic [1:0] CMD_TAKE  = 2'd2;

    // byte group lengths
    localparam logic [1:0] GL_ONE = 2'd1;
    localparam logic [1:0] GL_TWO = 2'd2;

    // position inside the group being sent
    localparam logic [1:0] GP_NONE   = 2'd0;
    localparam logic [1:0] GP_FIRST  = 2'd1;
    localparam logic [1:0] GP_SECOND = 2'd2;

    // holdoff register reset value
    localparam logic [3:0] HOLDOFF_RESET = 4'd2;

    // half-bit count at the end of eight data bits
    localparam logic [4:0] HALF_BIT_END = 5'd16;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_TX_CLK_LOW = 4'd1,
        PH_TX_CLK_REL = 4'd2,
        PH_TX_BITS    = 4'd3,
        PH_TX_PAR_REL = 4'd4,
        PH_TX_STOP    = 4'd5,
        PH_TX_END     = 4'd6,
        PH_RX_BITS    = 4'd7,
        PH_RX_A       = 4'd8,
        PH_RX_B       = 4'd9,
        PH_RX_C       = 4'd10,
        PH_RX_D       = 4'd11,
        PH_RX_END     = 4'd12
    } phase_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       clk_level;
        logic       data_level;
        logic [1:0] group_size;
        logic [7:0] byte_first;
        logic [7:0] byte_second;
    } item_t;

    typedef struct packed {
        logic       clk_drive_low;
        logic       data_drive_low;
        logic       rx_valid;
        logic [7:0] rx_value;
        logic       group_dropped;
    } result_t;

    // one queued group as held in the send queue
    typedef struct packed {
        logic       two;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
    } send_group_t;

endpackage

// ===== sv/ps2dle_fifo.sv =====
// ---------------------------------------------------------------------------
// ps2dle_fifo
// ring queue in a memory with the front entry prefetched into a register
// ---------------------------------------------------------------------------
module ps2dle_fifo #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic                       pop,
    input  logic [WIDTH-1:0]           push_data,
    output logic [WIDTH-1:0]           front,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    head_next;
    logic [AW-1:0]    tail_reg;
    logic [AW-1:0]    tail_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [WIDTH-1:0] rd_reg;
    logic             byp_reg;
    logic [WIDTH-1:0] byp_data_reg;

    // pointer and fill update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (pop)
        begin
            tail_next = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            byp_reg   <= push && (head_reg == tail_next);
        end
    end

    // memory write and prefetch of the next front entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[head_reg] <= push_data;
        end
        rd_reg       <= mem[tail_next];
        byp_data_reg <= push_data;
    end

    // a write to the front slot wins over the stale read
    assign front = byp_reg ? byp_data_reg : rd_reg;
    assign count = count_reg;

endmodule

// ===== sv/ps2_device_link_engine.sv =====
// ---------------------------------------------------------------------------
// ps2_device_link_engine
// order: an item is taken into the input register, then its result into the result register
// throughput: one item per cycle while the result is not stalled, set by the single
//   stage between the input register and the result register
// reset: asynchronous, lines released, queues empty, holdoff register 2
// ---------------------------------------------------------------------------
`include "ps2_device_link_engine_defines.svh"

module ps2_device_link_engine
    import ps2dle_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // handshake and stage registers
    logic        item_valid_reg;
    item_t       item_reg;
    logic        result_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    logic        advance;
    logic        process;

    // link state
    logic [3:0]  cfg_holdoff_reg;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [4:0]  half_reg;
    logic [4:0]  half_next;
    logic [7:0]  send_shift_reg;
    logic [7:0]  send_shift_next;
    logic [7:0]  recv_shift_reg;
    logic [7:0]  recv_shift_next;
    logic        parity_reg;
    logic        parity_next;
    logic [3:0]  holdoff_reg;
    logic [3:0]  holdoff_next;
    logic [1:0]  group_len_reg;
    logic [1:0]  group_len_next;
    logic [1:0]  group_pos_reg;
    logic [1:0]  group_pos_next;
    logic [CW-1:0] slot_count_reg;
    logic [CW-1:0] slot_count_next;
    logic        clk_hold_reg;
    logic        clk_hold_next;
    logic        data_hold_reg;
    logic        data_hold_next;

    // queue interfaces
    logic        grp_push;
    logic        grp_pop;
    send_group_t grp_in;
    send_group_t grp_front;
    logic [CW-1:0] grp_count;
    logic        rx_push;
    logic        rx_pop;
    logic [7:0]  rx_front;
    logic [CW-1:0] rx_count;
    logic [CW:0] need_slots;

    // send queue, one entry per group
    ps2dle_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(send_group_t))
    ) u_send_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (grp_push),
        .pop       (grp_pop),
        .push_data (grp_in),
        .front     (grp_front),
        .count     (grp_count)
    );

    // receive queue, one entry per byte
    ps2dle_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (8)
    ) u_recv_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rx_push),
        .pop       (rx_pop),
        .push_data (recv_shift_reg),
        .front     (rx_front),
        .count     (rx_count)
    );

    // stage flow
    assign advance      = !result_valid_reg || !result_stall;
    assign process      = item_valid_reg && advance;
    assign item_stall   = item_valid_reg && !advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign grp_in.two    = (item_reg.group_size == GL_TWO);
    assign grp_in.byte_a = item_reg.byte_first;
    assign grp_in.byte_b = item_reg.byte_second;

    // slots in use once this group is queued, its length entry included
    assign need_slots = {1'b0, slot_count_reg}
                      + (grp_in.two ? (CW+1)'(3) : (CW+1)'(2));

    // one item: link step, group queueing or byte take
    always_comb
    begin
        phase_next      = phase_reg;
        half_next       = half_reg;
        send_shift_next = send_shift_reg;
        recv_shift_next = recv_shift_reg;
        parity_next     = parity_reg;
        holdoff_next    = holdoff_reg;
        group_len_next  = group_len_reg;
        group_pos_next  = group_pos_reg;
        slot_count_next = slot_count_reg;
        clk_hold_next   = clk_hold_reg;
        data_hold_next  = data_hold_reg;
        grp_push        = 1'b0;
        grp_pop         = 1'b0;
        rx_push         = 1'b0;
        rx_pop          = 1'b0;
        result_next     = '0;

        if (process)
        begin
            unique case (item_reg.cmd)
                CMD_TICK:
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            priority if (!item_reg.clk_level)
                            begin
                                holdoff_next = cfg_holdoff_reg;
                            end
                            else if (!item_reg.data_level)
                            begin
                                half_next       = '0;
                                recv_shift_next = '0;
                                phase_next      = PH_RX_BITS;
                            end
                            else if (holdoff_reg != '0)
                            begin
                                holdoff_next = holdoff_reg - 4'd1;
                            end
                            else
                            begin
                                if (slot_count_reg != '0)
                                begin
                                    holdoff_next   = cfg_holdoff_reg;
                                    phase_next     = PH_TX_CLK_LOW;
                                    data_hold_next = 1'b1;
                                    // a fresh group consumes its length entry
                                    if (group_pos_reg == GP_NONE)
                                    begin
                                        group_len_next  = grp_front.two ? GL_TWO : GL_ONE;
                                        slot_count_next = slot_count_reg - 1'b1;
                                        group_pos_next  = GP_FIRST;
                                    end
                                    send_shift_next = (group_pos_reg == GP_SECOND) ?
                                                      grp_front.byte_b : grp_front.byte_a;
                                end
                            end
                        end
                        PH_TX_CLK_LOW:
                        begin
                            clk_hold_next = 1'b1;
                            phase_next    = PH_TX_CLK_REL;
                        end
                        PH_TX_CLK_REL:
                        begin
                            clk_hold_next = 1'b0;
                            phase_next    = PH_TX_BITS;
                            parity_next   = 1'b1;
                            half_next     = '0;
                        end
                        PH_TX_BITS:
                        begin
                            if (half_reg < HALF_BIT_END)
                            begin
                                if (!half_reg[0])
                                begin
                                    if (!item_reg.clk_level)
                                    begin
                                        // host holds the clock: abandon the frame
                                        phase_next     = PH_IDLE;
                                        group_pos_next = GP_FIRST;
                                        data_hold_next = 1'b0;
                                    end
                                    else
                                    begin
                                        data_hold_next = !send_shift_reg[0];
                                        parity_next    = parity_reg ^ send_shift_reg[0];
                                        clk_hold_next  = 1'b1;
                                    end
                                    send_shift_next = {1'b0, send_shift_reg[7:1]};
                                end
                                else
                                begin
                                    clk_hold_next = 1'b0;
                                end
                                half_next = half_reg + 5'd1;
                            end
                            else if (!item_reg.clk_level)
                            begin
                                phase_next     = PH_IDLE;
                                group_pos_next = GP_FIRST;
                                data_hold_next = 1'b0;
                            end
                            else
                            begin
                                data_hold_next = !parity_reg;
                                clk_hold_next  = 1'b1;
                                phase_next     = PH_TX_PAR_REL;
                            end
                        end
                        PH_TX_PAR_REL:
                        begin
                            clk_hold_next = 1'b0;
                            phase_next    = PH_TX_STOP;
                        end
                        PH_TX_STOP:
                        begin
                            if (!item_reg.clk_level)
                            begin
                                phase_next     = PH_IDLE;
                                group_pos_next = GP_FIRST;
                                data_hold_next = 1'b0;
                            end
                            else
                            begin
                                data_hold_next = 1'b0;
                                clk_hold_next  = 1'b1;
                                phase_next     = PH_TX_END;
                            end
                        end
                        PH_TX_END:
                        begin
                            clk_hold_next = 1'b0;
                            phase_next    = PH_IDLE;
                            // move on to the second byte or retire the group
                            if (group_pos_reg == GP_FIRST)
                            begin
                                if (group_len_reg == GL_TWO)
                                begin
                                    group_pos_next = GP_SECOND;
                                end
                                else
                                begin
                                    grp_pop         = 1'b1;
                                    slot_count_next = slot_count_reg - 1'b1;
                                    group_pos_next  = GP_NONE;
                                end
                            end
                            else if (group_pos_reg == GP_SECOND)
                            begin
                                grp_pop         = 1'b1;
                                slot_count_next = slot_count_reg - CW'(2);
                                group_pos_next  = GP_NONE;
                            end
                        end
                        PH_RX_BITS:
                        begin
                            if (half_reg < HALF_BIT_END)
                            begin
                                if (!half_reg[0])
                                begin
                                    clk_hold_next = 1'b1;
                                end
                                else
                                begin
                                    clk_hold_next   = 1'b0;
                                    recv_shift_next = {item_reg.data_level,
                                                       recv_shift_reg[7:1]};
                                end
                                half_next = half_reg + 5'd1;
                            end
                            else
                            begin
                                clk_hold_next = 1'b1;
                                half_next     = '0;
                                phase_next    = PH_RX_A;
                            end
                        end
                        PH_RX_A:
                        begin
                            clk_hold_next = 1'b0;
                            phase_next    = PH_RX_B;
                        end
                        PH_RX_B:
                        begin
                            clk_hold_next = 1'b1;
                            phase_next    = PH_RX_C;
                        end
                        PH_RX_C:
                        begin
                            clk_hold_next  = 1'b0;
                            data_hold_next = 1'b1;
                            phase_next     = PH_RX_D;
                        end
                        PH_RX_D:
                        begin
                            clk_hold_next = 1'b1;
                            phase_next    = PH_RX_END;
                        end
                        PH_RX_END:
                        begin
                            clk_hold_next  = 1'b0;
                            data_hold_next = 1'b0;
                            phase_next     = PH_IDLE;
                            // a full receive queue drops the byte
                            rx_push = (rx_count != CW'(QUEUE_DEPTH - 1));
                        end
                        default:
                        begin
                            clk_hold_next  = 1'b0;
                            data_hold_next = 1'b0;
                            phase_next     = PH_IDLE;
                        end
                    endcase
                end
                CMD_QUEUE:
                begin
                    if (need_slots > (CW+1)'(QUEUE_DEPTH - 1))
                    begin
                        result_next.group_dropped = 1'b1;
                    end
                    else
                    begin
                        grp_push        = 1'b1;
                        slot_count_next = slot_count_reg
                                        + (grp_in.two ? CW'(3) : CW'(2));
                    end
                end
                CMD_TAKE:
                begin
                    if (rx_count != '0)
                    begin
                        rx_pop               = 1'b1;
                        result_next.rx_valid = 1'b1;
                        result_next.rx_value = rx_front;
                    end
                end
                default:
                begin
                end
            endcase
        end

        result_next.clk_drive_low  = clk_hold_next;
        result_next.data_drive_low = data_hold_next;
    end

    // control and link state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            cfg_holdoff_reg  <= HOLDOFF_RESET;
            phase_reg        <= PH_IDLE;
            half_reg         <= '0;
            send_shift_reg   <= '0;
            recv_shift_reg   <= '0;
            parity_reg       <= 1'b0;
            holdoff_reg      <= '0;
            group_len_reg    <= '0;
            group_pos_reg    <= GP_NONE;
            slot_count_reg   <= '0;
            clk_hold_reg     <= 1'b0;
            data_hold_reg    <= 1'b0;
        end
        else
        begin
            if (!item_stall)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= item_valid_reg;
            end
            if (cfg_wr_en)
            begin
                cfg_holdoff_reg <= cfg_wr_data;
            end
            phase_reg      <= phase_next;
            half_reg       <= half_next;
            send_shift_reg <= send_shift_next;
            recv_shift_reg <= recv_shift_next;
            parity_reg     <= parity_next;
            holdoff_reg    <= holdoff_next;
            group_len_reg  <= group_len_next;
            group_pos_reg  <= group_pos_next;
            slot_count_reg <= slot_count_next;
            clk_hold_reg   <= clk_hold_next;
            data_hold_reg  <= data_hold_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
        if (process)
        begin
            result_reg <= result_next;
        end
    end

    // send slots are in use exactly while a group sits in the queue
    `PS2DLE_ASSERT_NOW(a_slots_match_groups, clk, rst_n, 1'b1,
        (slot_count_reg == '0) == (grp_count == '0))

    // the send queue keeps one slot spare
    `PS2DLE_ASSERT_NOW(a_slots_bounded, clk, rst_n, 1'b1,
        slot_count_reg <= CW'(QUEUE_DEPTH - 1))

    // the receive queue keeps one slot spare
    `PS2DLE_ASSERT_NOW(a_recv_bounded, clk, rst_n, 1'b1,
        rx_count <= CW'(QUEUE_DEPTH - 1))

    // input stalls only behind a held result
    `PS2DLE_ASSERT_NOW(a_stall_cause, clk, rst_n, item_stall,
        result_valid_reg && result_stall)

    // a mid-frame group always has its slots still counted
    `PS2DLE_ASSERT_NEXT(a_pos_has_group, clk, rst_n, group_pos_reg != GP_NONE,
        slot_count_reg != '0 || group_pos_reg == GP_NONE)

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// checks the ps2 device link engine item by item against a cycle-free
// predictor of the line state machine, byte queues and holdoff register,
// with random idling on both handshakes and several holdoff settings
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ps2dle_pkg::*;

    localparam int LINK_QDEPTH = 32;

    // codes outside the named ones, still legal on the port
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] GS_NONE    = 2'd0;
    localparam logic [1:0] GS_ODD     = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [3:0] cfg_wr_data;
    logic       item_valid;
    logic       item_stall;
    item_t      item;
    logic       result_valid;
    logic       result_stall;
    result_t    result;

    // stimulus side
    item_t   pending_items[$];
    int      items_outstanding;
    int      items_queued;
    int      send_idle_pct;
    int      recv_idle_pct;
    bit      item_fired;
    logic [3:0] holdoff_now;

    // predicted line engine state
    phase_t     link_ph;
    logic [4:0] half_cnt;
    logic [7:0] tx_shift;
    logic [7:0] rx_shift;
    logic       par;
    logic [3:0] holdoff_left;
    logic [3:0] holdoff_cfg;
    logic [1:0] grp_len;
    logic [1:0] grp_pos;
    logic [7:0] txq[LINK_QDEPTH];
    logic [7:0] rxq[LINK_QDEPTH];
    int         txq_head;
    int         txq_tail;
    int         rxq_head;
    int         rxq_tail;
    logic       clk_low;
    logic       data_low;
    result_t    link_results_due[$];

    // run statistics
    int errors;
    int items_taken;
    int results_checked;
    int bytes_returned;
    int groups_refused;
    int host_aborts;
    int rx_lost;

    ps2_device_link_engine #(
        .QUEUE_DEPTH (LINK_QDEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int qnext(input int idx);
        return (idx + 1) % LINK_QDEPTH;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns, result %0d: %s", $time, results_checked, msg);
        errors++;
    endtask

    // host held the clock low at a check point: resend the group from the start
    task automatic host_abort();
        link_ph = PH_IDLE;
        grp_pos = GP_FIRST;
        data_low = 1'b0;
        host_aborts++;
    endtask

    // one tick of line timing
    task automatic link_tick(input logic c, input logic d);
        case (link_ph)
            PH_IDLE:
            begin
                if (!c)
                    holdoff_left = holdoff_cfg;
                else if (!d)
                begin
                    half_cnt = '0;
                    rx_shift = '0;
                    link_ph = PH_RX_BITS;
                end
                else if (holdoff_left != 4'd0)
                    holdoff_left = holdoff_left - 4'd1;
                else if (txq_tail != txq_head)
                begin
                    holdoff_left = holdoff_cfg;
                    link_ph = PH_TX_CLK_LOW;
                    if (grp_pos == GP_NONE)
                    begin
                        grp_len = txq[txq_tail][1:0];
                        txq_tail = qnext(txq_tail);
                        grp_pos = GP_FIRST;
                    end
                    if (grp_pos == GP_SECOND)
                        tx_shift = txq[qnext(txq_tail)];
                    else
                        tx_shift = txq[txq_tail];
                    data_low = 1'b1;
                end
            end
            PH_TX_CLK_LOW:
            begin
                clk_low = 1'b1;
                link_ph = PH_TX_CLK_REL;
            end
            PH_TX_CLK_REL:
            begin
                clk_low = 1'b0;
                link_ph = PH_TX_BITS;
                par = 1'b1;
                half_cnt = '0;
            end
            PH_TX_BITS:
            begin
                if (half_cnt < HALF_BIT_END)
                begin
                    if (!half_cnt[0])
                    begin
                        if (!c)
                            host_abort();
                        else
                        begin
                            if (tx_shift[0])
                            begin
                                data_low = 1'b0;
                                par = ~par;
                            end
                            else
                                data_low = 1'b1;
                            clk_low = 1'b1;
                        end
                        tx_shift = tx_shift >> 1;
                    end
                    else
                        clk_low = 1'b0;
                    half_cnt = half_cnt + 5'd1;
                end
                else if (!c)
                    host_abort();
                else
                begin
                    data_low = ~par;
                    clk_low = 1'b1;
                    link_ph = PH_TX_PAR_REL;
                end
            end
            PH_TX_PAR_REL:
            begin
                clk_low = 1'b0;
                link_ph = PH_TX_STOP;
            end
            PH_TX_STOP:
            begin
                if (!c)
                    host_abort();
                else
                begin
                    data_low = 1'b0;
                    clk_low = 1'b1;
                    link_ph = PH_TX_END;
                end
            end
            PH_TX_END:
            begin
                clk_low = 1'b0;
                link_ph = PH_IDLE;
                if (grp_pos == GP_FIRST)
                begin
                    if (grp_len == GL_TWO)
                        grp_pos = GP_SECOND;
                    else
                    begin
                        txq_tail = qnext(txq_tail);
                        grp_pos = GP_NONE;
                    end
                end
                else if (grp_pos == GP_SECOND)
                begin
                    txq_tail = qnext(qnext(txq_tail));
                    grp_pos = GP_NONE;
                end
            end
            PH_RX_BITS:
            begin
                if (half_cnt < HALF_BIT_END)
                begin
                    if (!half_cnt[0])
                        clk_low = 1'b1;
                    else
                    begin
                        clk_low = 1'b0;
                        rx_shift = {d, rx_shift[7:1]};
                    end
                    half_cnt = half_cnt + 5'd1;
                end
                else
                begin
                    clk_low = 1'b1;
                    half_cnt = '0;
                    link_ph = PH_RX_A;
                end
            end
            PH_RX_A:
            begin
                clk_low = 1'b0;
                link_ph = PH_RX_B;
            end
            PH_RX_B:
            begin
                clk_low = 1'b1;
                link_ph = PH_RX_C;
            end
            PH_RX_C:
            begin
                clk_low = 1'b0;
                data_low = 1'b1;
                link_ph = PH_RX_D;
            end
            PH_RX_D:
            begin
                clk_low = 1'b1;
                link_ph = PH_RX_END;
            end
            PH_RX_END:
            begin
                clk_low = 1'b0;
                data_low = 1'b0;
                link_ph = PH_IDLE;
                if (qnext(rxq_head) != rxq_tail)
                begin
                    rxq[rxq_head] = rx_shift;
                    rxq_head = qnext(rxq_head);
                end
                else
                    rx_lost++;
            end
            default:
            begin
                clk_low = 1'b0;
                data_low = 1'b0;
                link_ph = PH_IDLE;
            end
        endcase
    endtask

    // expected result of one accepted item
    task automatic predict_link_result(input item_t it);
        result_t r;
        int fill;
        int len;
        r = '0;
        case (it.cmd)
            CMD_TICK:
                link_tick(it.clk_level, it.data_level);
            CMD_QUEUE:
            begin
                len = (it.group_size == GL_TWO) ? 2 : 1;
                fill = (txq_head + LINK_QDEPTH - txq_tail) % LINK_QDEPTH;
                if (len + 1 > LINK_QDEPTH - 1 - fill)
                begin
                    r.group_dropped = 1'b1;
                    groups_refused++;
                end
                else
                begin
                    txq[txq_head] = 8'(len);
                    txq_head = qnext(txq_head);
                    txq[txq_head] = it.byte_first;
                    txq_head = qnext(txq_head);
                    if (len == 2)
                    begin
                        txq[txq_head] = it.byte_second;
                        txq_head = qnext(txq_head);
                    end
                end
            end
            CMD_TAKE:
            begin
                if (rxq_tail != rxq_head)
                begin
                    r.rx_valid = 1'b1;
                    r.rx_value = rxq[rxq_tail];
                    rxq_tail = qnext(rxq_tail);
                    bytes_returned++;
                end
            end
            default:
            begin
            end
        endcase
        r.clk_drive_low = clk_low;
        r.data_drive_low = data_low;
        link_results_due.push_back(r);
    endtask

    // stimulus helpers
    task automatic push_item(input logic [1:0] cmd, input logic cl, input logic dl,
                             input logic [1:0] gs, input logic [7:0] b1,
                             input logic [7:0] b2);
        item_t it;
        it.cmd = cmd;
        it.clk_level = cl;
        it.data_level = dl;
        it.group_size = gs;
        it.byte_first = b1;
        it.byte_second = b2;
        pending_items.push_back(it);
        items_outstanding++;
        items_queued++;
    endtask

    task automatic push_cmd(input logic [1:0] cmd);
        push_item(cmd, 1'($urandom), 1'($urandom), 2'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    task automatic push_ticks(input int n, input logic cl, input logic dl);
        repeat (n)
            push_item(CMD_TICK, cl, dl, 2'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic push_group();
        logic [1:0] gs;
        int pick;
        pick = $urandom_range(9);
        gs = (pick < 4) ? GL_ONE : (pick < 8) ? GL_TWO : (pick == 8) ? GS_NONE : GS_ODD;
        push_item(CMD_QUEUE, 1'($urandom), 1'($urandom), gs, 8'($urandom), 8'($urandom));
    endtask

    // host to device byte: start bit, eight data bits, then ack ticks
    task automatic push_host_frame();
        push_ticks(1, 1'b1, 1'b0);
        repeat (16)
            push_ticks(1, 1'b1, 1'($urandom));
        push_ticks(6, 1'b1, 1'b1);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (items_outstanding != 0 || link_results_due.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_holdoff(input logic [3:0] value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        holdoff_now = value;
    endtask

    task automatic run_random_traffic(input int budget);
        int stop_at;
        int pick;
        stop_at = items_queued + budget;
        while (items_queued < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                // group sent in full with the clock left free
                push_group();
                push_ticks(2 * (holdoff_now + 24) + $urandom_range(5), 1'b1, 1'b1);
            end
            else if (pick < 50)
            begin
                // host holds the clock somewhere in the frame
                push_group();
                push_ticks(holdoff_now + 2 + $urandom_range(28), 1'b1, 1'b1);
                push_ticks(1 + $urandom_range(2), 1'b0, 1'b1);
                push_ticks(2 * (holdoff_now + 24), 1'b1, 1'b1);
            end
            else if (pick < 70)
            begin
                push_host_frame();
                if ($urandom_range(1))
                    push_cmd(CMD_TAKE);
            end
            else if (pick < 80)
                repeat (1 + $urandom_range(2))
                    push_cmd(CMD_TAKE);
            else if (pick < 90)
                repeat (1 + $urandom_range(4))
                    push_cmd(2'($urandom_range(3)));
            else
                repeat (1 + $urandom_range(5))
                    push_group();
        end
    endtask

    // item driver
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
        if (!item_valid || item_fired)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // predictor update and result check
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            item_fired = item_valid && !item_stall;
            if (cfg_wr_en)
                holdoff_cfg = cfg_wr_data;
            if (item_fired)
            begin
                predict_link_result(item);
                items_outstanding--;
                items_taken++;
            end
            if (result_valid && !result_stall)
            begin
                results_checked++;
                if (link_results_due.size() == 0)
                    report_mismatch("result with no item waiting for it");
                else
                begin
                    want = link_results_due.pop_front();
                    if (result.clk_drive_low !== want.clk_drive_low)
                        report_mismatch($sformatf("clk_drive_low %b, want %b",
                                        result.clk_drive_low, want.clk_drive_low));
                    if (result.data_drive_low !== want.data_drive_low)
                        report_mismatch($sformatf("data_drive_low %b, want %b",
                                        result.data_drive_low, want.data_drive_low));
                    if (result.rx_valid !== want.rx_valid)
                        report_mismatch($sformatf("rx_valid %b, want %b",
                                        result.rx_valid, want.rx_valid));
                    if (result.rx_value !== want.rx_value)
                        report_mismatch($sformatf("rx_value %h, want %h",
                                        result.rx_value, want.rx_value));
                    if (result.group_dropped !== want.group_dropped)
                        report_mismatch($sformatf("group_dropped %b, want %b",
                                        result.group_dropped, want.group_dropped));
                end
            end
        end
    end

    // stimulus and run control
    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 68;
        holdoff_now = HOLDOFF_RESET;

        // predictor out of reset
        holdoff_cfg = HOLDOFF_RESET;
        link_ph = PH_IDLE;
        half_cnt = '0;
        tx_shift = '0;
        rx_shift = '0;
        par = 1'b0;
        holdoff_left = '0;
        grp_len = '0;
        grp_pos = GP_NONE;
        txq_head = 0;
        txq_tail = 0;
        rxq_head = 0;
        rxq_tail = 0;
        clk_low = 1'b0;
        data_low = 1'b0;
        foreach (txq[i])
        begin
            txq[i] = '0;
            rxq[i] = '0;
        end

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty take, unused command, odd sizes, extreme bytes,
        // then two-byte groups until the send queue turns one away
        push_cmd(CMD_TAKE);
        push_item(CMD_UNUSED, 1'b1, 1'b1, 2'b11, 8'hFF, 8'hFF);
        push_item(CMD_QUEUE, 1'b0, 1'b0, GS_NONE, 8'h00, 8'hFF);
        push_item(CMD_QUEUE, 1'b1, 1'b1, GL_ONE, 8'hFF, 8'h00);
        push_item(CMD_QUEUE, 1'b0, 1'b1, GL_TWO, 8'h00, 8'hFF);
        push_item(CMD_QUEUE, 1'b1, 1'b0, GS_ODD, 8'hA5, 8'h5A);
        repeat (8)
            push_item(CMD_QUEUE, 1'b1, 1'b1, GL_TWO, 8'hFF, 8'h80);
        push_item(CMD_QUEUE, 1'b0, 1'b0, GL_ONE, 8'h01, 8'h00);
        push_ticks(1, 1'b0, 1'b0);
        push_cmd(CMD_TAKE);

        // sender idles less than the receiver, no holdoff
        write_holdoff(4'd0);
        run_random_traffic(60);
        // sender holds off until every result is back
        wait_drained();
        run_random_traffic(60);

        // receiver idles less than the sender, longest holdoff
        write_holdoff(4'd15);
        send_idle_pct = 68;
        recv_idle_pct = 33;
        run_random_traffic(110);

        // no idling: a burst of host bytes, take them all back, then mixed traffic
        write_holdoff(4'($urandom_range(1, 14)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4)
            push_host_frame();
        repeat (5)
            push_cmd(CMD_TAKE);
        run_random_traffic(60);

        wait_drained();
        repeat (4) @(negedge clk);

        $display("covered %0d items and %0d results: %0d bytes handed back, %0d groups refused",
                 items_taken, results_checked, bytes_returned, groups_refused);
        $display("host clock holds forcing a resend: %0d, bytes lost to a full receive queue: %0d",
                 host_aborts, rx_lost);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ps2dle_pkg.sv
sv/ps2dle_fifo.sv
sv/ps2_device_link_engine.sv
tb/testbench.sv
